FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge outside of reset.
`define SPT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that a condition never holds at a rising edge outside of reset.
`define SPT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SPT_ASSERT(label, clk, rst_n, prop)
`define SPT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hw/rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// Percent text generator package
// Beat types, font geometry and the 8x8 glyph table.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int GLYPH_SIZE = 8;
	localparam int ZOOM       = 3;
	localparam int CELL_W     = (GLYPH_SIZE + 1) * ZOOM;
	localparam int GLYPH_PX   = GLYPH_SIZE * ZOOM;

	localparam logic [6:0] PERCENT_MAX = 7'd100;
	localparam logic [3:0] GLYPH_PCT   = 4'd10;
	localparam logic [3:0] GLYPH_ONE   = 4'd1;
	localparam logic [3:0] GLYPH_ZERO  = 4'd0;

	typedef logic [3:0] glyph_id_t;

	typedef struct packed {
		logic [6:0] percent;
		logic [2:0] page;
		logic [6:0] column;
	} spt_req_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
	} spt_rsp_t;

	// Rows of each glyph: digits 0..9, then the percent sign.
	localparam logic [0:10][0:7][7:0] GLYPHS = '{
		'{8'h18, 8'h66, 8'h42, 8'h81, 8'h81, 8'h42, 8'h66, 8'h18},
		'{8'h10, 8'h18, 8'h14, 8'h10, 8'h10, 8'h10, 8'h10, 8'h3c},
		'{8'h00, 8'h18, 8'h24, 8'h20, 8'h20, 8'h10, 8'h08, 8'h3c},
		'{8'h00, 8'h18, 8'h24, 8'h20, 8'h30, 8'h20, 8'h24, 8'h18},
		'{8'h20, 8'h20, 8'h30, 8'h28, 8'h24, 8'h7e, 8'h20, 8'h20},
		'{8'h1e, 8'h02, 8'h02, 8'h0e, 8'h10, 8'h20, 8'h10, 8'h1e},
		'{8'h00, 8'h30, 8'h08, 8'h04, 8'h3c, 8'h44, 8'h44, 8'h38},
		'{8'h00, 8'h7c, 8'h40, 8'h20, 8'h10, 8'h08, 8'h08, 8'h08},
		'{8'h00, 8'h18, 8'h24, 8'h24, 8'h18, 8'h24, 8'h24, 8'h18},
		'{8'h30, 8'h28, 8'h24, 8'h24, 8'h38, 8'h20, 8'h20, 8'h20},
		'{8'h83, 8'h43, 8'h20, 8'h10, 8'h08, 8'h04, 8'hc2, 8'hc1}
	};

	function automatic logic [7:0] glyph_row(input glyph_id_t id, input logic [2:0] row);
		logic [7:0] bits;
		bits = '0;
		if (id <= GLYPH_PCT) begin
			bits = GLYPHS[id][row];
		end
		return bits;
	endfunction

	// Divide a value below 24 by three: (w * 11) >> 5 is exact there.
	function automatic logic [2:0] div3_small(input logic [4:0] w);
		logic [8:0] prod;
		prod = {4'd0, w} * 9'd11;
		return prod[7:5];
	endfunction

endpackage

FILE: hw/rtl/spt_chan_if.sv
// ----------------------------------------------------------------------------
// Ready/valid channel
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface spt_chan_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

FILE: hw/rtl/spt_render.sv
// ----------------------------------------------------------------------------
// Percent text renderer
// Maps one framebuffer position and value to its byte of lit pixels.
// ----------------------------------------------------------------------------
module spt_render
	import spt_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  spt_req_t   item,
	output logic [7:0] pixel_byte
);

	// Left edge of the text for one, two and three digits.
	localparam int X0_D1 = (DISPLAY_WIDTH - (2 * CELL_W - ZOOM)) / 2;
	localparam int X0_D2 = (DISPLAY_WIDTH - (3 * CELL_W - ZOOM)) / 2;
	localparam int X0_D3 = (DISPLAY_WIDTH - (4 * CELL_W - ZOOM)) / 2;
	localparam int Y0    = (DISPLAY_HEIGHT - GLYPH_PX) / 2;

	logic [6:0] value;
	logic [1:0] ndig;
	logic [7:0] x0;
	logic [7:0] span;
	logic [8:0] dx_full;
	logic       x_hit;
	logic [6:0] dx;
	logic [1:0] ci;
	logic [6:0] cell_off_full;
	logic [4:0] cell_off;
	logic [2:0] gcol;
	logic [3:0] tens;
	logic [3:0] ones;
	logic [14:0] tens_prod;
	logic [6:0] tens_x10;
	glyph_id_t  id;

	always_comb begin
		value = (item.percent > PERCENT_MAX) ? PERCENT_MAX : item.percent;
		if (value >= 7'd100) begin
			ndig = 2'd3;
			x0   = 8'(X0_D3);
			span = 8'(4 * CELL_W);
		end else if (value >= 7'd10) begin
			ndig = 2'd2;
			x0   = 8'(X0_D2);
			span = 8'(3 * CELL_W);
		end else begin
			ndig = 2'd1;
			x0   = 8'(X0_D1);
			span = 8'(2 * CELL_W);
		end

		dx_full = {2'b00, item.column} - {1'b0, x0};
		x_hit   = !dx_full[8] && (dx_full[7:0] < span)
			&& ({2'b00, item.column} < 9'(DISPLAY_WIDTH));
		dx      = dx_full[6:0];

		// Character cell and offset inside it.
		if (dx < 7'(CELL_W)) begin
			ci            = 2'd0;
			cell_off_full = dx;
		end else if (dx < 7'(2 * CELL_W)) begin
			ci            = 2'd1;
			cell_off_full = dx - 7'(CELL_W);
		end else if (dx < 7'(3 * CELL_W)) begin
			ci            = 2'd2;
			cell_off_full = dx - 7'(2 * CELL_W);
		end else begin
			ci            = 2'd3;
			cell_off_full = dx - 7'(3 * CELL_W);
		end
		cell_off = cell_off_full[4:0];
		gcol     = div3_small(cell_off);

		// Two-digit split: (v * 205) >> 11 equals v / 10 for v below 1029.
		tens_prod = {8'd0, value} * 15'd205;
		tens      = tens_prod[14:11];
		tens_x10  = 7'({3'd0, tens} * 7'd10);
		ones      = 4'(value - tens_x10);

		if (ci >= ndig) begin
			id = GLYPH_PCT;
		end else if (ndig == 2'd3) begin
			id = (ci == 2'd0) ? GLYPH_ONE : GLYPH_ZERO;
		end else if (ndig == 2'd2) begin
			id = (ci == 2'd0) ? tens : ones;
		end else begin
			id = value[3:0];
		end
	end

	always_comb begin
		logic [5:0] y;
		logic [7:0] dy_full;
		logic [7:0] row_bits;
		pixel_byte = '0;
		for (int k = 0; k < 8; k++) begin
			y        = {item.page, 3'(k)};
			dy_full  = {2'b00, y} - 8'(Y0);
			row_bits = glyph_row(id, div3_small(dy_full[4:0]));
			if (x_hit && (cell_off_full < 7'(GLYPH_PX))
				&& ({2'b00, y} < 8'(DISPLAY_HEIGHT))
				&& !dy_full[7] && (dy_full[6:0] < 7'(GLYPH_PX))) begin
				pixel_byte[k] = row_bits[gcol];
			end
		end
	end

endmodule

FILE: hw/rtl/scaled_percent_text_pixel_generator.sv
// ----------------------------------------------------------------------------
// Scaled percent text pixel generator: one framebuffer byte per beat.
// Beats pass the item register, a single render stage and the result register;
// throughput 1 beat/cycle while the sink is ready; back-pressure stalls both stages.
// Reset (arst_n low, asynchronous) empties both stages; no other state is kept.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_percent_text_pixel_generator
	import spt_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input logic         clk,
	input logic         arst_n,
	spt_chan_if.sink    req,
	spt_chan_if.source  rsp
);

	// Stage 1 holds the accepted request; the result register holds the
	// rendered byte until the sink takes it.
	spt_req_t   item_s1;
	logic       valid_s1;
	spt_rsp_t   rsp_q;
	logic       rsp_valid_q;
	logic       adv_s1;
	logic [7:0] byte_s1;

	// Advance stage 1 whenever the result register is empty or draining.
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp.ready);
	// Take a new beat whenever stage 1 is empty or moving on this cycle.
	assign req.ready = !valid_s1 || adv_s1;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Render the byte from the held request: glyph select, column, rows.
	spt_render #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT)
	) u_render (
		.item       (item_s1),
		.pixel_byte (byte_s1)
	);

	// Control: stage and result valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (adv_s1) begin
			rsp_q.pixel_byte <= byte_s1;
		end
	end

	// An accepted beat lands in stage 1.
	`SPT_ASSERT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready |=> valid_s1)
	// A stalled stage 1 keeps its request.
	`SPT_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
	// Advancing stage 1 always produces a result beat.
	`SPT_ASSERT(a_adv_to_rsp, clk, arst_n, adv_s1 |=> rsp_valid_q)
	// Never overwrite a held request.
	`SPT_ASSERT_NEVER(a_no_overwrite, clk, arst_n, req.ready && valid_s1 && !adv_s1)
	// Columns past the panel edge render dark.
	`SPT_ASSERT(a_offscreen_dark, clk, arst_n, adv_s1 && ({2'b00, item_s1.column} >= 9'(DISPLAY_WIDTH)) |=> rsp_q.pixel_byte == 8'h00)

endmodule
